>>> design/adl_pkg.sv
// Shared types and constants for the abridged length deframer.
// No dependencies; imported by the core, the output queue and the top level.
`default_nettype none

package adl_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned MAX_BODY_W  = 27;
   localparam int unsigned BODY_REM_W  = 26;
   localparam int unsigned LONG_LO_W   = 16;

   localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 27'd4194304;

   localparam logic [BYTE_W-1:0] HDR_SHORT_MIN = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_SHORT_MAX = 8'h7e;
   localparam logic [BYTE_W-1:0] HDR_LONG      = 8'h7f;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef enum logic [1:0] {
      PH_SHORT = 2'd0,
      PH_LONG  = 2'd1,
      PH_BODY  = 2'd2
   } phase_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data_byte;
      logic              first_of_packet;
      logic              last_of_packet;
   } result_type;

endpackage

`default_nettype wire

>>> design/abridged_length_deframer.sv
// Top level of the abridged length deframer: register port, core, result stage.
// Depends on adl_pkg, adl_core and adl_outq.
//
// Use: stream received bytes in on req_valid/req_stall/req_rx_byte, one item
// per byte. Header bytes give no result; each body byte comes out on the rsp_
// channel with first/last flags, and a bad header or bad long length gives one
// error result (rsp_kind = 1), after which all input is taken and dropped.
// Results reach rsp_ from the output register, via the skid register if stalled.
// Throughput: one byte per clock while req_stall is low, set by the single
// decode pass between the framing state registers and the result register.
// The result side is a two-entry stage (output register plus skid register):
// while the receiver stalls, one more result is absorbed, then req_stall rises
// (from a register) until the receiver takes an item.
// csr_ writes load max_body_bytes and are always ready; write only while idle.
// Reset (synchronous, active high) reopens the block, clears framing state,
// empties the result stage and restores max_body_bytes to 4194304.
`default_nettype none

module abridged_length_deframer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [adl_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_kind,
   output logic [adl_pkg::BYTE_W-1:0]          rsp_data_byte,
   output logic                                rsp_first_of_packet,
   output logic                                rsp_last_of_packet,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [adl_pkg::MAX_BODY_W-1:0] csr_max_body_bytes
);
   import adl_pkg::*;

   logic [MAX_BODY_W-1:0] max_body_ff;
   logic                  accept;
   logic                  res_valid;
   result_type            res;
   result_type            out_res;
   logic                  full;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else if (csr_valid && csr_ready) begin
         max_body_ff <= csr_max_body_bytes;
      end
   end

   adl_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_rx_byte),
      .max_body_bytes (max_body_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   adl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_res  (res),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (out_res)
   );

   assign rsp_kind            = out_res.kind;
   assign rsp_data_byte       = out_res.data_byte;
   assign rsp_first_of_packet = out_res.first_of_packet;
   assign rsp_last_of_packet  = out_res.last_of_packet;

endmodule

`default_nettype wire

>>> design/adl_core.sv
// Framing state and per-byte decode of the abridged length deframer.
// Depends on adl_pkg; produces at most one result per accepted item.
`default_nettype none

module adl_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [adl_pkg::BYTE_W-1:0]     rx_byte,
   input  wire logic [adl_pkg::MAX_BODY_W-1:0] max_body_bytes,
   output logic                                res_valid,
   output adl_pkg::result_type                 res
);
   import adl_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [1:0]             long_idx_ff, long_idx_in;
   logic [LONG_LO_W-1:0]   long_lo_ff, long_lo_in;
   logic [BODY_REM_W-1:0]  body_rem_ff, body_rem_in;
   logic                   at_start_ff, at_start_in;
   logic                   closed_ff, closed_in;

   logic                   last;
   logic [BODY_REM_W-1:0]  long_len;
   logic                   long_ok;

   assign last     = (body_rem_ff <= BODY_REM_W'(1));
   // word count is the two held bytes plus this one; bytes are four per word
   assign long_len = {rx_byte, long_lo_ff, 2'b00};
   assign long_ok  = (long_len != '0) && ({1'b0, long_len} < max_body_bytes);

   always_comb begin
      phase_in    = phase_ff;
      long_idx_in = long_idx_ff;
      long_lo_in  = long_lo_ff;
      body_rem_in = body_rem_ff;
      at_start_in = at_start_ff;
      closed_in   = closed_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (accept && !closed_ff) begin
         unique case (phase_ff)
            PH_BODY: begin
               res_valid           = 1'b1;
               res.kind            = KIND_DATA;
               res.data_byte       = rx_byte;
               res.first_of_packet = at_start_ff;
               res.last_of_packet  = last;
               at_start_in         = 1'b0;
               if (last) begin
                  body_rem_in = '0;
                  phase_in    = PH_SHORT;
               end else begin
                  body_rem_in = body_rem_ff - BODY_REM_W'(1);
               end
            end
            PH_LONG: begin
               if (long_idx_ff == 2'd2) begin
                  long_idx_in = '0;
                  long_lo_in  = '0;
                  if (long_ok) begin
                     body_rem_in = long_len;
                     at_start_in = 1'b1;
                     phase_in    = PH_BODY;
                  end else begin
                     res_valid = 1'b1;
                     res.kind  = KIND_ERROR;
                     closed_in = 1'b1;
                     phase_in  = PH_SHORT;
                  end
               end else begin
                  if (long_idx_ff[0]) begin
                     long_lo_in[15:8] = rx_byte;
                  end else begin
                     long_lo_in[7:0] = rx_byte;
                  end
                  long_idx_in = long_idx_ff + 2'd1;
               end
            end
            default: begin
               // short header, also the unused phase code
               if (rx_byte >= HDR_SHORT_MIN && rx_byte <= HDR_SHORT_MAX) begin
                  body_rem_in = {16'd0, rx_byte, 2'b00};
                  at_start_in = 1'b1;
                  phase_in    = PH_BODY;
               end else if (rx_byte == HDR_LONG) begin
                  long_idx_in = '0;
                  long_lo_in  = '0;
                  phase_in    = PH_LONG;
               end else begin
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  closed_in = 1'b1;
                  phase_in  = PH_SHORT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SHORT;
         long_idx_ff <= '0;
         long_lo_ff  <= '0;
         body_rem_ff <= '0;
         at_start_ff <= 1'b1;
         closed_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         long_idx_ff <= long_idx_in;
         long_lo_ff  <= long_lo_in;
         body_rem_ff <= body_rem_in;
         at_start_ff <= at_start_in;
         closed_ff   <= closed_in;
      end
   end

endmodule

`default_nettype wire

>>> design/adl_outq.sv
// Two-entry result stage: output register plus skid register.
// Depends on adl_pkg; stalls the producer only when both entries are full.
`default_nettype none

module adl_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire adl_pkg::result_type push_res,
   output logic                     full,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output adl_pkg::result_type      out_res
);
   import adl_pkg::*;

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // producer is held off; drain skid into main
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

>>> design/adl_checker.sv
// Port-level checks for the abridged length deframer, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module adl_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic       rsp_first_of_packet,
   input wire logic       rsp_last_of_packet
);

   logic closed_seen_ff;

   // latch once an error item has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         closed_seen_ff <= 1'b0;
      end else if (rsp_valid && !rsp_stall && rsp_kind) begin
         closed_seen_ff <= 1'b1;
      end
   end

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |->
         rsp_data_byte == 8'd0 && !rsp_first_of_packet && !rsp_last_of_packet)
      else $error("error item carries data or flags");

   a_no_short_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind && rsp_first_of_packet |-> !rsp_last_of_packet)
      else $error("packet body shorter than one word");

   a_silent_after_close: assert property (@(posedge clock) disable iff (reset)
      closed_seen_ff |-> !rsp_valid)
      else $error("item delivered after framing error");

   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind abridged_length_deframer adl_checker u_adl_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kind            (rsp_kind),
   .rsp_data_byte       (rsp_data_byte),
   .rsp_first_of_packet (rsp_first_of_packet),
   .rsp_last_of_packet  (rsp_last_of_packet)
);

`default_nettype wire

>>> tb/sv/abridged_length_deframer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for abridged_length_deframer: bursty byte driver, stalling result
// monitor and an in-bench framing predictor. Depends on adl_pkg and the deframer RTL.

module abridged_length_deframer_tb;
   import adl_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_LEN    = 400;

   typedef enum int {
      CLOSE_ZERO_HDR,
      CLOSE_HIGH_HDR,
      CLOSE_ZERO_COUNT,
      CLOSE_AT_LIMIT,
      CLOSE_FAR_ABOVE
   } close_kind_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_kind;
   logic [BYTE_W-1:0]     rsp_data_byte;
   logic                  rsp_first_of_packet;
   logic                  rsp_last_of_packet;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [MAX_BODY_W-1:0] csr_max_body_bytes = '0;

   abridged_length_deframer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_first_of_packet (rsp_first_of_packet),
      .rsp_last_of_packet  (rsp_last_of_packet),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_body_bytes  (csr_max_body_bytes)
   );

   always #5 clock = ~clock;

   // bytes still to be sent and results still owed by the block
   logic [BYTE_W-1:0] rx_stream[$];
   result_type        due_results[$];

   // framing state mirrored by the predictor
   phase_type             ph;
   logic [1:0]            long_idx;
   logic [23:0]           long_acc;
   logic [BODY_REM_W-1:0] body_left;
   logic                  pkt_start;
   logic                  closed;
   logic [MAX_BODY_W-1:0] limit_bytes;

   int   fail_count = 0;
   int   results_checked = 0;
   int   n_short = 0;
   int   n_long = 0;
   int   n_body = 0;
   int   csr_writes = 0;
   int   cycle_count = 0;
   bit   item_taken = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;
   int   rx_cycles = 0;
   int   stall_mode = 0;
   int   hold_left = 0;
   result_type got_r;
   result_type want_r;

   task automatic clear_framer();
      ph        = PH_SHORT;
      long_idx  = '0;
      long_acc  = '0;
      body_left = '0;
      pkt_start = 1'b1;
      closed    = 1'b0;
   endtask

   task automatic close_stream();
      result_type r;
      r        = '0;
      r.kind   = KIND_ERROR;
      closed   = 1'b1;
      ph       = PH_SHORT;
      due_results.push_back(r);
   endtask

   task automatic deframe_byte(input logic [BYTE_W-1:0] b);
      result_type      r;
      logic [26:0]     len;
      r = '0;
      if (!closed) begin
         case (ph)
            PH_BODY: begin
               r.kind            = KIND_DATA;
               r.data_byte       = b;
               r.first_of_packet = pkt_start;
               r.last_of_packet  = (body_left <= 1);
               pkt_start = 1'b0;
               if (r.last_of_packet) begin
                  body_left = '0;
                  ph        = PH_SHORT;
               end else begin
                  body_left = body_left - 1'b1;
               end
               due_results.push_back(r);
            end
            PH_LONG: begin
               long_acc = long_acc | (24'(b) << (8 * long_idx));
               long_idx = long_idx + 1'b1;
               if (long_idx == 2'd3) begin
                  long_idx = '0;
                  len      = {1'b0, long_acc, 2'b00};
                  long_acc = '0;
                  if (len != 0 && len < limit_bytes) begin
                     body_left = len[BODY_REM_W-1:0];
                     pkt_start = 1'b1;
                     ph        = PH_BODY;
                  end else begin
                     close_stream();
                  end
               end
            end
            default: begin
               if (b >= HDR_SHORT_MIN && b <= HDR_SHORT_MAX) begin
                  body_left = {16'd0, b, 2'b00};
                  pkt_start = 1'b1;
                  ph        = PH_BODY;
               end else if (b == HDR_LONG) begin
                  long_idx = '0;
                  long_acc = '0;
                  ph       = PH_LONG;
               end else begin
                  close_stream();
               end
            end
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %02h, got %02h", name, want, got);
         fail_count++;
      end
   endtask

   // largest word count that the current limit still accepts
   function automatic int top_words();
      return int'((limit_bytes - 1'b1) >> 2);
   endfunction

   task automatic add_body(input int n);
      repeat (n) rx_stream.push_back(8'($urandom_range(0, 255)));
      n_body += n;
   endtask

   task automatic add_short(input int words);
      rx_stream.push_back(8'(words));
      add_body(4 * words);
      n_short++;
   endtask

   task automatic add_long(input logic [23:0] count, input bit with_body);
      rx_stream.push_back(HDR_LONG);
      rx_stream.push_back(count[7:0]);
      rx_stream.push_back(count[15:8]);
      rx_stream.push_back(count[23:16]);
      if (with_body) add_body(4 * int'(count));
      n_long++;
   endtask

   // well-formed packets only: any framing error closes the block for good
   task automatic add_traffic(input int target);
      int added;
      int words;
      int max_words;
      added     = 0;
      max_words = top_words();
      while (added < target) begin
         if (max_words != 0 && $urandom_range(0, 3) == 0) begin
            words = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 160) : $urandom_range(1, 16);
            if (words > max_words) words = max_words;
            add_long(24'(words), 1'b1);
            added += 4 + 4 * words;
         end else begin
            words = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 126) : $urandom_range(1, 8);
            add_short(words);
            added += 1 + 4 * words;
         end
      end
   endtask

   task automatic write_max(input logic [MAX_BODY_W-1:0] value);
      int n;
      n = csr_writes;
      @(negedge clock);
      csr_max_body_bytes <= value;
      csr_valid          <= 1'b1;
      while (csr_writes == n) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every byte is taken and every owed result has come back
   task automatic drain(input int extra);
      int waited;
      waited = 0;
      while (rx_stream.size() != 0 || req_valid) @(negedge clock);
      while (due_results.size() != 0 && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      if (due_results.size() != 0) begin
         $error("%0d results never arrived", due_results.size());
         fail_count++;
         due_results.delete();
      end
      repeat (extra) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         limit_bytes <= MAX_BODY_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_bytes <= csr_max_body_bytes;
         csr_writes  <= csr_writes + 1;
      end
   end

   // accept side: predict on every item the block takes
   always @(posedge clock) begin
      if (reset) begin
         clear_framer();
         item_taken <= 1'b0;
      end else begin
         item_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            deframe_byte(req_rx_byte);
            rx_stream.delete(0);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !item_taken) begin
         // hold the offered item until it is taken
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left  <= gap_left - 1;
      end else if (rx_stream.size() != 0) begin
         req_valid   <= 1'b1;
         req_rx_byte <= rx_stream[0];
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: rotating stall patterns plus two long hold-offs
   always @(negedge clock) begin
      rx_cycles <= rx_cycles + 1;
      if (rx_cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      if (rx_cycles == 300 || rx_cycles == 1500) hold_left <= HOLD_LEN;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      case (stall_mode)
         0: rsp_stall <= (hold_left != 0);
         1: rsp_stall <= (hold_left != 0) || ($urandom_range(0, 3) == 0);
         2: rsp_stall <= (hold_left != 0) || (rx_cycles % 3 == 0);
         default: rsp_stall <= (hold_left != 0) || ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_r = '{rsp_kind, rsp_data_byte, rsp_first_of_packet, rsp_last_of_packet};
         if (due_results.size() == 0) begin
            $error("unexpected item: kind %0d data %02h first %0d last %0d",
                   rsp_kind, rsp_data_byte, rsp_first_of_packet, rsp_last_of_packet);
            fail_count++;
         end else begin
            want_r = due_results.pop_front();
            check_field("kind", 8'(want_r.kind), 8'(got_r.kind));
            check_field("data_byte", want_r.data_byte, got_r.data_byte);
            check_field("first_of_packet", 8'(want_r.first_of_packet), 8'(got_r.first_of_packet));
            check_field("last_of_packet", 8'(want_r.last_of_packet), 8'(got_r.last_of_packet));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, due_results.size());
         $display("abridged_length_deframer_tb NOT OK");
         $finish;
      end
   end

   initial begin
      close_kind_type close_case;
      int             edge_words;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // default limit: smallest and largest short packets, short long-form ones
      rx_stream.push_back(HDR_SHORT_MIN);
      rx_stream.push_back(8'h00);
      rx_stream.push_back(8'hff);
      rx_stream.push_back(8'h80);
      rx_stream.push_back(8'h7f);
      n_short++;
      n_body += 4;
      add_short(int'(HDR_SHORT_MAX));
      add_long(24'd1, 1'b1);
      add_long(24'd2, 1'b1);
      add_short(1);
      drain(4);

      // lowest limit rejects every long form, so short packets only
      write_max(27'd4);
      add_traffic(100);
      drain(4);

      write_max(27'd67108864);
      add_traffic(180);
      drain(4);

      write_max(27'($urandom_range(8, 400)));
      add_long(24'(top_words()), 1'b1);
      add_traffic(120);
      drain(4);

      write_max(MAX_BODY_RESET);
      add_traffic(100);
      drain(4);

      // closing phase: one framing error, then everything is dropped
      write_max(27'($urandom_range(16, 128)));
      add_traffic(60);
      edge_words = top_words();
      add_long(24'(edge_words), 1'b1);
      close_case = close_kind_type'($urandom_range(0, 4));
      case (close_case)
         CLOSE_ZERO_HDR:   rx_stream.push_back(8'h00);
         CLOSE_HIGH_HDR:   rx_stream.push_back(8'($urandom_range(128, 255)));
         CLOSE_ZERO_COUNT: add_long(24'd0, 1'b0);
         CLOSE_AT_LIMIT:   add_long(24'(edge_words + 1), 1'b0);
         default:          add_long(24'($urandom_range(edge_words + 1, 24'hffffff)), 1'b0);
      endcase
      add_short(2);
      add_body(30);
      drain(8);

      $display("covered %0d short and %0d long-form packets, %0d body bytes, %0d items checked",
               n_short, n_long, n_body, results_checked);
      $display("six limit settings incl. 4 and 2^26; stream closed by %s", close_case.name());
      if (fail_count == 0) begin
         $display("abridged_length_deframer_tb OK");
      end else begin
         $display("abridged_length_deframer_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/adl_pkg.sv
design/adl_core.sv
design/adl_outq.sv
design/abridged_length_deframer.sv
design/adl_checker.sv
tb/sv/abridged_length_deframer_tb.sv
